// ----- hw/rtl/nnb_pkg.sv -----
// Shared types and constants of the nearest-neighbour blit address generator.
package nnb_pkg;

  localparam int PANEL_WIDTH_DEF    = 1024;
  localparam int PANEL_HEIGHT_DEF   = 600;
  localparam int SOURCE_MAX_DIM_DEF = 1024;

  localparam int COORD_W    = 10;
  localparam int FRAME_W    = 20;
  localparam int CLAMP_W    = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_LEFT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_TOP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT = 3'd5;

  localparam logic [10:0]        RST_SOURCE_WIDTH  = 11'd1024;
  localparam logic [10:0]        RST_SOURCE_HEIGHT = 11'd600;
  localparam logic signed [11:0] RST_TARGET_LEFT   = 12'sd0;
  localparam logic signed [11:0] RST_TARGET_TOP    = 12'sd0;
  localparam logic signed [11:0] RST_TARGET_WIDTH  = 12'sd1024;
  localparam logic signed [11:0] RST_TARGET_HEIGHT = 12'sd600;

  typedef struct packed {
    logic [10:0]        source_width;
    logic [10:0]        source_height;
    logic signed [11:0] target_left;
    logic signed [11:0] target_top;
    logic signed [11:0] target_width;
    logic signed [11:0] target_height;
  } cfg_t;

  typedef struct packed {
    logic [9:0] out_col;
    logic [9:0] out_row;
  } item_t;

  typedef struct packed {
    logic [19:0] source_index;
    logic [19:0] frame_index;
    logic        pixel_valid;
    logic        rect_drawable;
    logic [9:0]  clamped_left;
    logic [9:0]  clamped_top;
    logic [10:0] clamped_width;
    logic [9:0]  clamped_height;
  } result_t;

  typedef struct packed {
    logic        valid;
    logic        pixel_valid;
    logic        rect_drawable;
    logic [9:0]  clamped_left;
    logic [9:0]  clamped_top;
    logic [10:0] clamped_width;
    logic [9:0]  clamped_height;
    logic [19:0] frame_index;
  } side_t;

endpackage

// ----- hw/rtl/nnb_cfg.sv -----
// Configuration register file of the blit address generator.
module nnb_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [nnb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [nnb_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output nnb_pkg::cfg_t                  cfg_o
);
  import nnb_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source_width  <= RST_SOURCE_WIDTH;
      cfg_q.source_height <= RST_SOURCE_HEIGHT;
      cfg_q.target_left   <= RST_TARGET_LEFT;
      cfg_q.target_top    <= RST_TARGET_TOP;
      cfg_q.target_width  <= RST_TARGET_WIDTH;
      cfg_q.target_height <= RST_TARGET_HEIGHT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SOURCE_WIDTH:  cfg_q.source_width  <= cfg_wdata_i[10:0];
        REG_SOURCE_HEIGHT: cfg_q.source_height <= cfg_wdata_i[10:0];
        REG_TARGET_LEFT:   cfg_q.target_left   <= $signed(cfg_wdata_i);
        REG_TARGET_TOP:    cfg_q.target_top    <= $signed(cfg_wdata_i);
        REG_TARGET_WIDTH:  cfg_q.target_width  <= $signed(cfg_wdata_i);
        REG_TARGET_HEIGHT: cfg_q.target_height <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/nnb_front.sv -----
// Front stages: rectangle clamp, pixel check, frame index and source products.
module nnb_front #(
  parameter int PANEL_WIDTH    = nnb_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT   = nnb_pkg::PANEL_HEIGHT_DEF,
  parameter int SOURCE_MAX_DIM = nnb_pkg::SOURCE_MAX_DIM_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  nnb_pkg::item_t                         item_i,
  input  nnb_pkg::cfg_t                          cfg_i,
  input  logic [$clog2(SOURCE_MAX_DIM+1)-1:0]    sw_i,
  input  logic [$clog2(SOURCE_MAX_DIM+1)-1:0]    sh_i,
  output nnb_pkg::side_t                         side_o,
  output logic [nnb_pkg::COORD_W+$clog2(SOURCE_MAX_DIM+1)-1:0] prow_o,
  output logic [nnb_pkg::COORD_W+$clog2(SOURCE_MAX_DIM+1)-1:0] pcol_o,
  output logic [$clog2(PANEL_HEIGHT+1)-1:0]      ch_o,
  output logic [$clog2(PANEL_WIDTH+1)-1:0]       cw_o
);
  import nnb_pkg::*;

  localparam int SDW = $clog2(SOURCE_MAX_DIM + 1);
  localparam int NW  = COORD_W + SDW;
  localparam int CWW = $clog2(PANEL_WIDTH + 1);
  localparam int CHW = $clog2(PANEL_HEIGHT + 1);
  localparam logic signed [CLAMP_W-1:0] PW_S = CLAMP_W'(PANEL_WIDTH);
  localparam logic signed [CLAMP_W-1:0] PH_S = CLAMP_W'(PANEL_HEIGHT);

  logic signed [CLAMP_W-1:0] x0, y0, w0, h0;
  logic signed [CLAMP_W-1:0] x1_d, y1_d, w1_d, h1_d;
  logic                      ok1_d;

  logic                      v1_q;
  logic [COORD_W-1:0]        col1_q, row1_q;
  logic signed [CLAMP_W-1:0] x1_q, y1_q, w1_q, h1_q;
  logic                      ok1_q;
  logic [NW-1:0]             prow1_q, pcol1_q;

  logic signed [CLAMP_W-1:0] sum_x, sum_y, w2, h2;
  logic                      ok2;
  logic                      pix2;
  logic [FRAME_W-1:0]        fy, fidx;
  side_t                     side_d, side_q;
  logic [CWW-1:0]            cw_d, cw_q;
  logic [CHW-1:0]            ch_d, ch_q;
  logic [NW-1:0]             prow2_q, pcol2_q;

  // stage 1: move negative origins to zero, shrink the size to match, pre-check drawability, form source products
  always_comb begin
    x0 = CLAMP_W'($signed(cfg_i.target_left));
    y0 = CLAMP_W'($signed(cfg_i.target_top));
    w0 = CLAMP_W'($signed(cfg_i.target_width));
    h0 = CLAMP_W'($signed(cfg_i.target_height));
    x1_d = x0[CLAMP_W-1] ? '0 : x0;
    w1_d = x0[CLAMP_W-1] ? w0 + x0 : w0;
    y1_d = y0[CLAMP_W-1] ? '0 : y0;
    h1_d = y0[CLAMP_W-1] ? h0 + y0 : h0;
    ok1_d = !w0[CLAMP_W-1] && (w0 != '0) && !h0[CLAMP_W-1] && (h0 != '0) &&
            (x1_d < PW_S) && (y1_d < PH_S);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    col1_q  <= item_i.out_col;
    row1_q  <= item_i.out_row;
    x1_q    <= x1_d;
    y1_q    <= y1_d;
    w1_q    <= w1_d;
    h1_q    <= h1_d;
    ok1_q   <= ok1_d;
    prow1_q <= NW'(item_i.out_row) * NW'(sh_i);
    pcol1_q <= NW'(item_i.out_col) * NW'(sw_i);
  end

  // stage 2: cut overhang, check pixel, form frame index
  always_comb begin
    sum_x = x1_q + w1_q;
    sum_y = y1_q + h1_q;
    w2    = (sum_x > PW_S) ? PW_S - x1_q : w1_q;
    h2    = (sum_y > PH_S) ? PH_S - y1_q : h1_q;
    ok2   = ok1_q && !w2[CLAMP_W-1] && (w2 != '0) && !h2[CLAMP_W-1] && (h2 != '0);
    pix2  = ok2 && ($unsigned(CLAMP_W'(col1_q)) < $unsigned(w2)) &&
            ($unsigned(CLAMP_W'(row1_q)) < $unsigned(h2));
    fy    = FRAME_W'(y1_q) + FRAME_W'(row1_q);
    fidx  = fy * FRAME_W'(PANEL_WIDTH) + FRAME_W'(x1_q) + FRAME_W'(col1_q);
    cw_d  = ok2 ? CWW'(w2) : '0;
    ch_d  = ok2 ? CHW'(h2) : '0;

    side_d                = '0;
    side_d.valid          = v1_q;
    side_d.pixel_valid    = pix2;
    side_d.rect_drawable  = ok2;
    side_d.clamped_left   = ok2 ? 10'(x1_q) : '0;
    side_d.clamped_top    = ok2 ? 10'(y1_q) : '0;
    side_d.clamped_width  = ok2 ? 11'(w2) : '0;
    side_d.clamped_height = ok2 ? 10'(h2) : '0;
    side_d.frame_index    = pix2 ? fidx : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else begin
      side_q <= side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cw_q    <= cw_d;
    ch_q    <= ch_d;
    prow2_q <= prow1_q;
    pcol2_q <= pcol1_q;
  end

  assign side_o = side_q;
  assign prow_o = prow2_q;
  assign pcol_o = pcol2_q;
  assign cw_o   = cw_q;
  assign ch_o   = ch_q;

endmodule

// ----- hw/rtl/nnb_div.sv -----
// Pipelined restoring divider, one quotient bit per register stage.
module nnb_div #(
  parameter int NW = 21,
  parameter int DW = 11,
  parameter int QW = 10
) (
  input  logic          clk_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic [QW-1:0] quotient_o
);

  localparam int RW = NW + DW;

  logic [RW-1:0] rem_q [QW];
  logic [DW-1:0] div_q [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int B = QW - 1 - s;

    logic [RW-1:0] rem_in, sub;
    logic [DW-1:0] div_in;
    logic [QW-1:0] quo_in;

    if (s == 0) begin : g_first
      assign rem_in = RW'(dividend_i);
      assign div_in = divisor_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign div_in = div_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    assign sub = RW'(div_in) << B;

    always_ff @(posedge clk_i) begin
      div_q[s] <= div_in;
      if (rem_in >= sub) begin
        rem_q[s] <= rem_in - sub;
        quo_q[s] <= quo_in | (QW'(1) << B);
      end else begin
        rem_q[s] <= rem_in;
        quo_q[s] <= quo_in;
      end
    end
  end

  assign quotient_o = quo_q[QW-1];

endmodule

// ----- hw/rtl/nearest_neighbour_blit_address_gen_top.sv -----
// Top level of the nearest-neighbour blit address generator.
//
//   channel   direction  handshake            payload
//   item      in         start / busy         item_i   (out_col, out_row)
//   result    out        done_o strobe        result_o (indices, flags, rectangle)
//   config    in         cfg_we_i             cfg_idx_i, cfg_wdata_i
//
// One item enters per cycle; busy stays low.
// Each result passes the front stages, then the divider pipeline that yields one
// source row and column bit per stage, then the output register.
// Reset clears the configuration to its defaults and all stage valid bits.
// The receiver cannot stall: each result is shown for one cycle under done_o.
module nearest_neighbour_blit_address_gen_top #(
  parameter int PANEL_WIDTH    = nnb_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT   = nnb_pkg::PANEL_HEIGHT_DEF,
  parameter int SOURCE_MAX_DIM = nnb_pkg::SOURCE_MAX_DIM_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  nnb_pkg::item_t                 item_i,
  output logic                           done_o,
  output nnb_pkg::result_t               result_o,
  input  logic                           cfg_we_i,
  input  logic [nnb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [nnb_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import nnb_pkg::*;

  localparam int SDW = $clog2(SOURCE_MAX_DIM + 1);
  localparam int QW  = $clog2(SOURCE_MAX_DIM);
  localparam int NW  = COORD_W + SDW;
  localparam int CWW = $clog2(PANEL_WIDTH + 1);
  localparam int CHW = $clog2(PANEL_HEIGHT + 1);
  localparam int SIW = QW + SDW + 1;

  cfg_t           cfg;
  logic [SDW-1:0] sw_sat, sh_sat;
  side_t          front_side;
  logic [NW-1:0]  prow, pcol;
  logic [CWW-1:0] cw;
  logic [CHW-1:0] ch;
  logic [QW-1:0]  srow, scol;
  side_t          side_q [QW];
  logic [SIW-1:0] sidx_wide;
  logic           done_q;
  result_t        result_q;

  nnb_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign sw_sat = (32'(cfg.source_width) > 32'(SOURCE_MAX_DIM)) ?
                  SDW'(SOURCE_MAX_DIM) : SDW'(cfg.source_width);
  assign sh_sat = (32'(cfg.source_height) > 32'(SOURCE_MAX_DIM)) ?
                  SDW'(SOURCE_MAX_DIM) : SDW'(cfg.source_height);

  assign busy = 1'b0;

  nnb_front #(
    .PANEL_WIDTH    (PANEL_WIDTH),
    .PANEL_HEIGHT   (PANEL_HEIGHT),
    .SOURCE_MAX_DIM (SOURCE_MAX_DIM)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start && !busy),
    .item_i  (item_i),
    .cfg_i   (cfg),
    .sw_i    (sw_sat),
    .sh_i    (sh_sat),
    .side_o  (front_side),
    .prow_o  (prow),
    .pcol_o  (pcol),
    .ch_o    (ch),
    .cw_o    (cw)
  );

  nnb_div #(.NW(NW), .DW(CHW), .QW(QW)) u_div_row (
    .clk_i      (clk_i),
    .dividend_i (prow),
    .divisor_i  (ch),
    .quotient_o (srow)
  );

  nnb_div #(.NW(NW), .DW(CWW), .QW(QW)) u_div_col (
    .clk_i      (clk_i),
    .dividend_i (pcol),
    .divisor_i  (cw),
    .quotient_o (scol)
  );

  // hold item side data alongside the divider stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < QW; s++) begin
        side_q[s] <= '0;
      end
    end else begin
      side_q[0] <= front_side;
      for (int s = 1; s < QW; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  assign sidx_wide = SIW'(srow) * SIW'(sw_sat) + SIW'(scol);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= side_q[QW-1].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q.source_index   <= side_q[QW-1].pixel_valid ? 20'(sidx_wide) : '0;
    result_q.frame_index    <= side_q[QW-1].frame_index;
    result_q.pixel_valid    <= side_q[QW-1].pixel_valid;
    result_q.rect_drawable  <= side_q[QW-1].rect_drawable;
    result_q.clamped_left   <= side_q[QW-1].clamped_left;
    result_q.clamped_top    <= side_q[QW-1].clamped_top;
    result_q.clamped_width  <= side_q[QW-1].clamped_width;
    result_q.clamped_height <= side_q[QW-1].clamped_height;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##(QW + 3) done_o)
    else $error("item result missing at expected latency");

  a_valid_drawable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.pixel_valid |-> result_o.rect_drawable)
    else $error("valid pixel on undrawable rectangle");

  a_undrawable_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !result_o.rect_drawable |->
      result_o.clamped_width == '0 && result_o.clamped_height == '0)
    else $error("undrawable rectangle with nonzero size");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !result_o.pixel_valid |->
      result_o.source_index == '0 && result_o.frame_index == '0)
    else $error("invalid pixel with nonzero index");
`endif

endmodule
